// ----- src/ptw_pkg.sv -----
`timescale 1ns / 1ps

package ptw_pkg;

  // descriptor layout
  localparam int DESC_W     = 64;
  localparam int BIT_VALID  = 0;
  localparam int BIT_TABLE  = 1;
  localparam int PAGE_SHIFT = 12;
  localparam int OA_HI      = 47;
  localparam int INDEX_BITS = 9;
  localparam int LEVELS     = 3;

  // address widths
  localparam int VA_W      = 48;
  localparam int WALK_VA_W = PAGE_SHIFT + LEVELS * INDEX_BITS;
  localparam int WORD_IDX_W = 15;
  localparam int CFG_W     = 6;
  localparam logic [CFG_W-1:0] VA_W_MIN   = 6'd25;
  localparam logic [CFG_W-1:0] VA_W_MAX   = 6'd39;
  localparam logic [CFG_W-1:0] VA_W_RESET = 6'd39;

  // register indexes on the config port
  localparam logic REG_ROOT_TABLE_FRAME = 1'b0;
  localparam logic REG_VA_WIDTH         = 1'b1;

  // fault codes
  localparam logic [2:0] FAULT_NONE    = 3'd0;
  localparam logic [2:0] FAULT_RANGE   = 3'd1;
  localparam logic [2:0] FAULT_TABLE   = 3'd2;
  localparam logic [2:0] FAULT_LEAF    = 3'd3;
  localparam logic [2:0] FAULT_OUTSIDE = 3'd4;

  // input operations
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SKIP  = 2'd1,
    CMD_WALK  = 2'd2,
    CMD_RANGE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [WORD_IDX_W-1:0] word_index;
    logic [DESC_W-1:0]     value;
    logic [WALK_VA_W-1:0]  va;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- src/ptw_ram.sv -----
`timescale 1ns / 1ps

module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ptw_queue.sv -----
`timescale 1ns / 1ps

module ptw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ptw_pkg::item_t push_item,
  input  logic           pop,
  output ptw_pkg::item_t pop_item,
  output ptw_pkg::qstat_t stat
);
  import ptw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            ent [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_item   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- src/ptw_front.sv -----
`timescale 1ns / 1ps

module ptw_front #(
  parameter int TABLE_FRAMES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [ptw_pkg::CFG_W-1:0]           root_table_frame,
  // request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                operation,
  input  logic [ptw_pkg::WORD_IDX_W-1:0]      table_word_index,
  input  logic [ptw_pkg::DESC_W-1:0]          descriptor_value,
  input  logic [ptw_pkg::VA_W-1:0]            virtual_address,
  // queue interface and store-clear status
  input  ptw_pkg::qstat_t                     q_stat,
  input  logic                                clearing,
  output logic                                push,
  output ptw_pkg::item_t                      push_item
);
  import ptw_pkg::*;

  localparam int STORE_WORDS = TABLE_FRAMES * (1 << INDEX_BITS);

  logic [CFG_W-1:0] va_width;
  logic [CFG_W-1:0] va_w_eff;
  logic [VA_W-1:0]  limit_mask;
  logic             va_over;
  logic             cfg_wr;
  logic             word_in_store;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_frame <= '0;
      va_width         <= VA_W_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROOT_TABLE_FRAME) begin
        root_table_frame <= pwdata[CFG_W-1:0];
      end else begin
        va_width <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_VA_WIDTH) begin
      prdata = {{(32-CFG_W){1'b0}}, va_width};
    end else begin
      prdata = {{(32-CFG_W){1'b0}}, root_table_frame};
    end
  end

  // clamp the width so the three index fields always cover accepted addresses
  always_comb begin
    if (va_width < VA_W_MIN) begin
      va_w_eff = VA_W_MIN;
    end else if (va_width > VA_W_MAX) begin
      va_w_eff = VA_W_MAX;
    end else begin
      va_w_eff = va_width;
    end
    limit_mask = ~((VA_W'(1) << va_w_eff) - VA_W'(1));
    va_over    = |(virtual_address & limit_mask);
  end

  assign word_in_store = (32'(table_word_index) < 32'(STORE_WORDS));

  assign req_stall = q_stat.full || clearing;
  assign push      = req_valid && !req_stall;

  always_comb begin
    push_item.word_index = table_word_index;
    push_item.value      = descriptor_value;
    push_item.va         = virtual_address[WALK_VA_W-1:0];
    if (operation == OP_WRITE) begin
      push_item.cmd = word_in_store ? CMD_WRITE : CMD_SKIP;
    end else begin
      push_item.cmd = va_over ? CMD_RANGE : CMD_WALK;
    end
  end

endmodule

// ----- src/ptw_back.sv -----
`timescale 1ns / 1ps

module ptw_back #(
  parameter int TABLE_FRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ptw_pkg::qstat_t               q_stat,
  input  ptw_pkg::item_t                q_item,
  output logic                          q_pop,
  input  logic [ptw_pkg::CFG_W-1:0]     root_table_frame,
  output logic                          clearing,
  // result channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          mapped,
  output logic [ptw_pkg::VA_W-1:0]      physical_address,
  output logic [ptw_pkg::DESC_W-1:0]    leaf_descriptor,
  output logic [2:0]                    fault_code
);
  import ptw_pkg::*;

  localparam int FRAME_W = $clog2(TABLE_FRAMES);
  localparam int ADDR_W  = FRAME_W + INDEX_BITS;
  localparam int DEPTH   = TABLE_FRAMES * (1 << INDEX_BITS);
  localparam int OA_W    = OA_HI - PAGE_SHIFT + 1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_L1    = 5'b00100,
    ST_L2    = 5'b01000,
    ST_L3    = 5'b10000
  } state_t;

  state_t                state, state_next;
  logic [ADDR_W-1:0]     clr_addr;
  logic [WALK_VA_W-1:0]  walk_va;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DESC_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DESC_W-1:0]     ram_rdata;

  logic                  out_free;
  logic                  load;
  logic                  mapped_next;
  logic [VA_W-1:0]       pa_next;
  logic [DESC_W-1:0]     leaf_next;
  logic [2:0]            code_next;

  logic [OA_W-1:0]       desc_frame;
  logic                  desc_frame_bad;
  logic                  root_bad;
  logic [INDEX_BITS-1:0] next_idx;
  state_t                next_level;

  ptw_ram #(
    .WIDTH(DESC_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign clearing = (state == ST_CLEAR);
  assign out_free = !rsp_valid || !rsp_stall;

  assign desc_frame     = ram_rdata[OA_HI:PAGE_SHIFT];
  assign desc_frame_bad = (desc_frame >= OA_W'(TABLE_FRAMES));
  assign root_bad       = (32'(root_table_frame) >= 32'(TABLE_FRAMES));

  assign next_idx   = (state == ST_L1) ? walk_va[PAGE_SHIFT + INDEX_BITS +: INDEX_BITS]
                                       : walk_va[PAGE_SHIFT +: INDEX_BITS];
  assign next_level = (state == ST_L1) ? ST_L2 : ST_L3;

  // store write: clearing sweep or a write beat from the queue
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = q_pop && (q_item.cmd == CMD_WRITE);
      ram_waddr = ADDR_W'(q_item.word_index);
      ram_wdata = q_item.value;
    end
  end

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    load        = 1'b0;
    mapped_next = 1'b0;
    pa_next     = '0;
    leaf_next   = '0;
    code_next   = FAULT_NONE;
    ram_raddr   = '0;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_stat.empty && out_free) begin
          q_pop = 1'b1;
          case (q_item.cmd)
            CMD_WALK: begin
              if (root_bad) begin
                load      = 1'b1;
                code_next = FAULT_OUTSIDE;
              end else begin
                ram_raddr  = {FRAME_W'(root_table_frame),
                              q_item.va[PAGE_SHIFT + 2*INDEX_BITS +: INDEX_BITS]};
                state_next = ST_L1;
              end
            end
            CMD_RANGE: begin
              load      = 1'b1;
              code_next = FAULT_RANGE;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_L1, ST_L2: begin
        if (!ram_rdata[BIT_VALID] || !ram_rdata[BIT_TABLE]) begin
          load       = 1'b1;
          code_next  = FAULT_TABLE;
          state_next = ST_IDLE;
        end else if (desc_frame_bad) begin
          load       = 1'b1;
          code_next  = FAULT_OUTSIDE;
          state_next = ST_IDLE;
        end else begin
          ram_raddr  = {FRAME_W'(desc_frame), next_idx};
          state_next = next_level;
        end
      end
      ST_L3: begin
        load       = 1'b1;
        state_next = ST_IDLE;
        if (!ram_rdata[BIT_VALID]) begin
          code_next = FAULT_LEAF;
        end else begin
          mapped_next = 1'b1;
          pa_next     = {ram_rdata[OA_HI:PAGE_SHIFT], walk_va[PAGE_SHIFT-1:0]};
          leaf_next   = ram_rdata;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      walk_va <= q_item.va;
    end
  end

  // result register: a walk only starts with this register free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mapped           <= mapped_next;
      physical_address <= pa_next;
      leaf_descriptor  <= leaf_next;
      fault_code       <= code_next;
    end
  end

endmodule

// ----- src/three_level_page_table_walker.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------------------------
// req      | req_valid/req_stall | operation, table_word_index,
//          |                     | descriptor_value, virtual_address
// rsp      | rsp_valid/rsp_stall | mapped, physical_address, leaf_descriptor,
//          |                     | fault_code
// cfg      | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// A write beat, a VA-limit fault or a root frame outside the store is finished in
// the walk engine's idle state, a fault on the level 1 or level 2 entry in ST_L1
// or ST_L2; a full translate goes on through ST_L3, as its three dependent reads
// share the one read port of the descriptor store. A two-entry queue lets requests
// land while a result waits. After reset the store is zeroed one word a cycle,
// with req_stall held high; config writes are taken throughout.
module three_level_page_table_walker #(
  parameter int TABLE_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        operation,
  input  logic [14:0] table_word_index,
  input  logic [63:0] descriptor_value,
  input  logic [47:0] virtual_address,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        mapped,
  output logic [47:0] physical_address,
  output logic [63:0] leaf_descriptor,
  output logic [2:0]  fault_code
);
  import ptw_pkg::*;

  logic             push;
  item_t            push_item;
  logic             q_pop;
  item_t            q_item;
  qstat_t           q_stat;
  logic             clearing;
  logic [CFG_W-1:0] root_table_frame;

  ptw_front #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .root_table_frame(root_table_frame),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .operation       (operation),
    .table_word_index(table_word_index),
    .descriptor_value(descriptor_value),
    .virtual_address (virtual_address),
    .q_stat          (q_stat),
    .clearing        (clearing),
    .push            (push),
    .push_item       (push_item)
  );

  ptw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (q_pop),
    .pop_item (q_item),
    .stat     (q_stat)
  );

  ptw_back #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_stat          (q_stat),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .root_table_frame(root_table_frame),
    .clearing        (clearing),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .mapped          (mapped),
    .physical_address(physical_address),
    .leaf_descriptor (leaf_descriptor),
    .fault_code      (fault_code)
  );

`ifndef SYNTHESIS
  a_mapped_no_fault: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && mapped |-> fault_code == FAULT_NONE)
    else $error("mapped result carries a fault code");

  a_fault_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && fault_code != FAULT_NONE |->
      !mapped && physical_address == '0 && leaf_descriptor == '0)
    else $error("faulted result carries address or leaf");

  a_clear_blocks_req: assert property (@(posedge clk) disable iff (rst)
    clearing |-> req_stall && !q_pop)
    else $error("request taken during store clear");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("walk engine popped an empty queue");
`endif

endmodule
